/* hdl/cdi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdi_pkg
// shared types and constants of the codebook delay interleaver
// ----------------------------------------------------------------------------
package cdi_pkg;

    localparam int NCH       = 8;                  // codebook channels
    localparam int CODE_BITS = 12;                 // bits per code
    localparam int DEPTH     = NCH;                // delay line entries per lane
    localparam int DIST_BITS = $clog2(NCH);        // row distance / row count
    localparam int CNT_BITS  = $clog2(NCH + 1);    // channel count
    localparam int IDX_BITS  = 2;                  // config register index

    typedef logic [CODE_BITS-1:0] code_t;
    typedef logic [DIST_BITS-1:0] dist_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_ACTIVE    = 2'd0,
        REG_PAD       = 2'd1,
        REG_DIRECTION = 2'd2
    } reg_idx_t;

    typedef enum logic {
        DIR_DELAY   = 1'b0,
        DIR_UNDELAY = 1'b1
    } dir_t;

    // control shared by all lanes for the row being built
    typedef struct packed {
        logic  flush;   // draining rows after the last frame
        dist_t k;       // flush row number
        dist_t rs;      // rows seen before the current row
        cnt_t  n;       // channels in use, clamped
        dir_t  dir;
        code_t pad;
    } ctl_t;

    typedef struct packed {
        code_t [NCH-1:0] code;
        logic            last;
    } row_t;

endpackage : cdi_pkg
`default_nettype wire

/* hdl/cdi_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdi_lane
// one channel: delay line of past codes and selection of the output code
// ----------------------------------------------------------------------------
module cdi_lane
(
    input  wire logic           clk,
    input  wire cdi_pkg::dist_t lane_id,
    input  wire cdi_pkg::ctl_t  ctl,
    input  wire logic           shift_en,
    input  wire cdi_pkg::code_t cur,
    output cdi_pkg::code_t      code
);
    import cdi_pkg::*;

    code_t dly_reg [DEPTH];

    cnt_t  c_ext;
    logic  active;
    logic  from_cur;
    logic  avail;
    dist_t lag;
    dist_t idx;
    code_t src;

    // newest code at entry 0
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            dly_reg[0] <= cur;
            for (int j = 1; j < DEPTH; j++)
            begin
                dly_reg[j] <= dly_reg[j-1];
            end
        end
    end

    always_comb
    begin
        c_ext    = cnt_t'(lane_id);
        active   = c_ext < ctl.n;
        lag      = lane_id;
        from_cur = 1'b0;
        idx      = '0;
        if (ctl.flush)
        begin
            // line already holds the last frame at entry 0
            active = active && (lane_id >= ctl.k);
            lag    = lane_id - ctl.k;
            idx    = lag;
        end
        else
        begin
            if (ctl.dir == DIR_UNDELAY)
                lag = dist_t'(ctl.n - cnt_t'(1) - c_ext);
            else
                lag = lane_id;
            from_cur = (lag == '0);
            idx      = lag - dist_t'(1);
        end
        avail = (lag <= ctl.rs);
        src   = from_cur ? cur : dly_reg[idx];
        code  = (active && avail) ? src : ctl.pad;
    end

endmodule : cdi_lane
`default_nettype wire

/* hdl/cdi_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdi_merge
// gathers the lane codes into one row and buffers rows in two slots
// ----------------------------------------------------------------------------
module cdi_merge
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cdi_pkg::code_t [cdi_pkg::NCH-1:0] lane_code,
    input  wire logic                        row_last,
    input  wire logic                        push,
    output logic                             full,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output cdi_pkg::row_t                    head
);
    import cdi_pkg::*;

    row_t       new_row;
    row_t       head_reg;
    row_t       skid_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign new_row.code = lane_code;
    assign new_row.last = row_last;

    assign pop       = (cnt_reg != 2'd0) && out_ready;
    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign head      = head_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_reg == 2'd2)
        begin
            if (pop)
                head_reg <= skid_reg;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0 || pop)
                head_reg <= new_row;
            else
                skid_reg <= new_row;
        end
    end

endmodule : cdi_merge
`default_nettype wire

/* hdl/codebook_delay_interleaver.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// codebook_delay_interleaver
// converts frames of codebook codes between aligned and delayed layouts
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    in_code0..in_code7, last_frame
//  output    out_valid / out_ready  out_code0..out_code7, last_out
//  config    cfg_we                 cfg_index, cfg_data
//
//  one input word per cycle while in_ready is high; each row is built in the
//  cycle the word is taken and is registered into a two-slot output buffer
//  the last frame in delay mode adds active_channels-1 flush rows, one per
//  cycle while not full, taking no input word; this flush sets the worst case
//  reset clears the row count, flush state, buffer and registers to defaults
//  a stalled output fills the buffer and then drops in_ready
// ----------------------------------------------------------------------------
module codebook_delay_interleaver
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input words
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire cdi_pkg::code_t       in_code0,
    input  wire cdi_pkg::code_t       in_code1,
    input  wire cdi_pkg::code_t       in_code2,
    input  wire cdi_pkg::code_t       in_code3,
    input  wire cdi_pkg::code_t       in_code4,
    input  wire cdi_pkg::code_t       in_code5,
    input  wire cdi_pkg::code_t       in_code6,
    input  wire cdi_pkg::code_t       in_code7,
    input  wire logic                 last_frame,
    // output words
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output cdi_pkg::code_t            out_code0,
    output cdi_pkg::code_t            out_code1,
    output cdi_pkg::code_t            out_code2,
    output cdi_pkg::code_t            out_code3,
    output cdi_pkg::code_t            out_code4,
    output cdi_pkg::code_t            out_code5,
    output cdi_pkg::code_t            out_code6,
    output cdi_pkg::code_t            out_code7,
    output logic                      last_out,
    // configuration writes
    input  wire logic                 cfg_we,
    input  wire logic [cdi_pkg::IDX_BITS-1:0] cfg_index,
    input  wire cdi_pkg::code_t       cfg_data
);
    import cdi_pkg::*;

    // configuration registers
    logic [3:0] active_reg;
    code_t      pad_reg;
    dir_t       dir_reg;

    // sequence state
    dist_t rows_seen_reg;
    logic  flush_reg;
    dist_t flush_k_reg;
    dist_t flush_rs_reg;

    cnt_t  n_eff;
    logic  in_fire;
    logic  full;
    logic  emit_und;
    logic  push;
    logic  row_last;
    logic  flush_end;
    ctl_t  ctl;
    row_t  head;

    code_t [NCH-1:0] cur;
    code_t [NCH-1:0] lane_code;

    assign cur[0] = in_code0;
    assign cur[1] = in_code1;
    assign cur[2] = in_code2;
    assign cur[3] = in_code3;
    assign cur[4] = in_code4;
    assign cur[5] = in_code5;
    assign cur[6] = in_code6;
    assign cur[7] = in_code7;

    // channel count: zero acts as one, too many acts as all
    always_comb
    begin
        priority if (active_reg == 4'd0)
            n_eff = cnt_t'(1);
        else if (active_reg > 4'(NCH))
            n_eff = cnt_t'(NCH);
        else
            n_eff = cnt_t'(active_reg);
    end

    assign in_ready = !flush_reg && !full;
    assign in_fire  = in_valid && in_ready;

    // undelay gives a row once enough rows are stored
    assign emit_und  = (cnt_t'(rows_seen_reg) + cnt_t'(1)) >= n_eff;
    assign flush_end = (cnt_t'(flush_k_reg) == n_eff - cnt_t'(1));

    always_comb
    begin
        if (flush_reg)
        begin
            push     = !full;
            row_last = flush_end;
        end
        else if (dir_reg == DIR_DELAY)
        begin
            push     = in_fire;
            row_last = last_frame && (n_eff == cnt_t'(1));
        end
        else
        begin
            push     = in_fire && emit_und;
            row_last = last_frame;
        end
    end

    // lane control for the row under construction
    assign ctl.flush = flush_reg;
    assign ctl.k     = flush_k_reg;
    assign ctl.rs    = flush_reg ? flush_rs_reg : rows_seen_reg;
    assign ctl.n     = n_eff;
    assign ctl.dir   = dir_reg;
    assign ctl.pad   = pad_reg;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 4'd8;
            pad_reg    <= code_t'(1024);
            dir_reg    <= DIR_DELAY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACTIVE:    active_reg <= cfg_data[3:0];
                REG_PAD:       pad_reg    <= cfg_data;
                REG_DIRECTION: dir_reg    <= dir_t'(cfg_data[0]);
                default:       ;
            endcase
        end
    end

    // row count and flush sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_seen_reg <= '0;
            flush_reg     <= 1'b0;
            flush_k_reg   <= '0;
            flush_rs_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                if (last_frame)
                    rows_seen_reg <= '0;
                else if (rows_seen_reg != dist_t'(NCH - 1))
                    rows_seen_reg <= rows_seen_reg + dist_t'(1);
                // delay mode drains the lines after the last frame
                if (last_frame && dir_reg == DIR_DELAY && n_eff != cnt_t'(1))
                begin
                    flush_reg    <= 1'b1;
                    flush_k_reg  <= dist_t'(1);
                    flush_rs_reg <= rows_seen_reg;
                end
            end
            else if (flush_reg && !full)
            begin
                if (flush_end)
                    flush_reg <= 1'b0;
                else
                    flush_k_reg <= flush_k_reg + dist_t'(1);
            end
        end
    end

    // one lane per channel
    for (genvar i = 0; i < NCH; i++)
    begin : g_lane
        cdi_lane u_lane
        (
            .clk      (clk),
            .lane_id  (dist_t'(i)),
            .ctl      (ctl),
            .shift_en (in_fire),
            .cur      (cur[i]),
            .code     (lane_code[i])
        );
    end

    cdi_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_code (lane_code),
        .row_last  (row_last),
        .push      (push),
        .full      (full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_code0 = head.code[0];
    assign out_code1 = head.code[1];
    assign out_code2 = head.code[2];
    assign out_code3 = head.code[3];
    assign out_code4 = head.code[4];
    assign out_code5 = head.code[5];
    assign out_code6 = head.code[6];
    assign out_code7 = head.code[7];
    assign last_out  = head.last;

endmodule : codebook_delay_interleaver
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for codebook_delay_interleaver: a queue-fed driver pushes
// frames through the valid/ready input with random gaps, a clocked monitor
// predicts the delayed or undelayed rows of every accepted word and checks each
// output word field by field, settings change only while the block is idle
// ----------------------------------------------------------------------------
module tb_top;

    import cdi_pkg::*;

    localparam int CLK_HALF    = 4;        // 8 ns period
    localparam int RESET_TICKS = 5;
    localparam int IDLE_TICKS  = 4;        // pause before a settings change
    localparam int RANDOM_GOAL = 360;      // random input words
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;       // mismatch lines shown

    // content of a directed frame
    typedef enum int {
        FILL_ZERO,
        FILL_ONES,
        FILL_CHECKER,
        FILL_RANDOM
    } fill_t;

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    code_t    in_code0, in_code1, in_code2, in_code3;
    code_t    in_code4, in_code5, in_code6, in_code7;
    logic     last_frame;
    logic     out_valid;
    logic     out_ready;
    code_t    out_code0, out_code1, out_code2, out_code3;
    code_t    out_code4, out_code5, out_code6, out_code7;
    logic     last_out;
    logic     cfg_we;
    reg_idx_t cfg_index;
    code_t    cfg_data;

    codebook_delay_interleaver dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_code0   (in_code0),
        .in_code1   (in_code1),
        .in_code2   (in_code2),
        .in_code3   (in_code3),
        .in_code4   (in_code4),
        .in_code5   (in_code5),
        .in_code6   (in_code6),
        .in_code7   (in_code7),
        .last_frame (last_frame),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_code0  (out_code0),
        .out_code1  (out_code1),
        .out_code2  (out_code2),
        .out_code3  (out_code3),
        .out_code4  (out_code4),
        .out_code5  (out_code5),
        .out_code6  (out_code6),
        .out_code7  (out_code7),
        .last_out   (last_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    row_t pending_words[$];     // frames waiting for the driver
    row_t expected_rows[$];     // predicted output words, oldest first

    int words_queued  = 0;
    int words_taken   = 0;
    int rows_checked  = 0;
    int rows_expected = 0;
    int mismatches    = 0;
    int settings_used = 0;
    int cycles        = 0;

    logic took_word;            // input word accepted at the last rising edge
    int   send_gap  = 0;
    int   send_calm = 0;
    int   recv_gap  = 0;
    int   recv_calm = 0;

    // predictor copy of the registers and the delay lines
    logic [3:0] active_reg;
    code_t      pad_reg;
    dir_t       dir_reg;
    code_t      code_hist [NCH][NCH];   // per channel, newest row first
    int         rows_seen;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // code of channel ch from lag rows back; before the sequence start reads pad
    function automatic code_t past_code(int ch, int lag, row_t word);
        if (lag == 0)
            return word.code[ch];
        if (lag > rows_seen)
            return pad_reg;
        return code_hist[ch][lag-1];
    endfunction

    function automatic void predict_word(row_t word);
        row_t row;
        int   n;
        int   nrows;
        n = (active_reg == 0) ? 1 : (active_reg > NCH) ? NCH : int'(active_reg);
        if (dir_reg == DIR_DELAY)
        begin
            // one delayed row, plus the flush rows on the last frame
            nrows = word.last ? n : 1;
            for (int k = 0; k < nrows; k++)
            begin
                for (int c = 0; c < NCH; c++)
                    row.code[c] = (c < n && c >= k) ? past_code(c, c - k, word) : pad_reg;
                row.last = word.last && (k == nrows - 1);
                expected_rows = {expected_rows, row};
                rows_expected++;
            end
        end
        else if (rows_seen + 1 >= n)
        begin
            // undelay: channel c is advanced by c rows
            for (int c = 0; c < NCH; c++)
                row.code[c] = (c < n) ? past_code(c, n - 1 - c, word) : pad_reg;
            row.last = word.last;
            expected_rows = {expected_rows, row};
            rows_expected++;
        end
        // short undelay sequences fall through with no row
        if (word.last)
        begin
            rows_seen = 0;
            foreach (code_hist[c, d])
                code_hist[c][d] = pad_reg;
        end
        else
        begin
            for (int c = 0; c < NCH; c++)
            begin
                for (int d = NCH - 1; d > 0; d--)
                    code_hist[c][d] = code_hist[c][d-1];
                code_hist[c][0] = word.code[c];
            end
            if (rows_seen < NCH - 1)
                rows_seen++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [CODE_BITS-1:0] got,
                                   logic [CODE_BITS-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch %s: got %h, expected %h", $time, what, got, want);
    endtask

    // idle length: mostly short, a few long, and calm stretches with none
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic code_t any_code();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return code_t'($urandom);
    endfunction

    task automatic push_word(fill_t fill, logic is_last);
        row_t w;
        for (int c = 0; c < NCH; c++)
            case (fill)
                FILL_ZERO:    w.code[c] = '0;
                FILL_ONES:    w.code[c] = '1;
                FILL_CHECKER: w.code[c] = c[0] ? 12'h555 : 12'hAAA;
                default:      w.code[c] = any_code();
            endcase
        w.last = is_last;
        pending_words = {pending_words, w};
        words_queued++;
    endtask

    task automatic write_reg(reg_idx_t idx, code_t value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ACTIVE:    active_reg = value[3:0];
            REG_PAD:       pad_reg    = value;
            REG_DIRECTION: dir_reg    = dir_t'(value[0]);
            default:       ;
        endcase
    endtask

    task automatic apply_settings(int active, code_t pad, dir_t dir);
        write_reg(REG_ACTIVE, code_t'(active));
        write_reg(REG_PAD, pad);
        write_reg(REG_DIRECTION, code_t'(dir));
        settings_used++;
    endtask

    // block idle: every word taken, every row seen, then a short pause
    task automatic wait_idle();
        while (words_taken != words_queued || expected_rows.size() != 0)
            @(posedge clk);
        repeat (IDLE_TICKS) @(posedge clk);
    endtask

    // mostly whole sequences with random content; some cut short, some noisy
    task automatic fill_phase(int budget);
        int  left;
        int  len;
        bit  close;
        bit  noisy;
        left = budget;
        while (left > 0)
        begin
            len   = $urandom_range(1, 2 * NCH + 2);
            close = 1'b1;
            noisy = ($urandom_range(0, 7) == 0);
            if (len >= left)
            begin
                len   = left;
                // a phase may end inside a sequence, carried over the next change
                close = ($urandom_range(0, 3) != 0);
            end
            for (int i = 0; i < len; i++)
                if (noisy)
                    push_word(FILL_RANDOM, logic'($urandom_range(0, 3) == 0));
                else
                    push_word(FILL_RANDOM, close && (i == len - 1));
            left -= len;
        end
    endtask

    // ------------------------------------------------------------------------
    // input driver: changes at the falling edge, holds a word until taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : word_driver
        row_t w;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !took_word)
        begin
            // word still waiting for in_ready
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            in_valid <= 1'b0;
        end
        else if (pending_words.size() != 0)
        begin
            w = pending_words.pop_front();
            in_code0   <= w.code[0];
            in_code1   <= w.code[1];
            in_code2   <= w.code[2];
            in_code3   <= w.code[3];
            in_code4   <= w.code[4];
            in_code5   <= w.code[5];
            in_code6   <= w.code[6];
            in_code7   <= w.code[7];
            last_frame <= w.last;
            in_valid   <= 1'b1;
            send_gap   = idle_len(send_calm);
        end
        else
            in_valid <= 1'b0;
    end

    // output back-pressure: a ready cycle, then a stall of random length
    always @(negedge clk)
    begin : ready_driver
        if (!rst_n)
            out_ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            recv_gap  = idle_len(recv_calm);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on every taken word, checks every output word
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : port_monitor
        row_t word;
        row_t got;
        row_t want;
        if (!rst_n)
            took_word <= 1'b0;
        else
        begin
            took_word <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                word.code = {in_code7, in_code6, in_code5, in_code4,
                             in_code3, in_code2, in_code1, in_code0};
                word.last = last_frame;
                predict_word(word);
                words_taken++;
            end
            if (out_valid && out_ready)
            begin
                got.code = {out_code7, out_code6, out_code5, out_code4,
                            out_code3, out_code2, out_code1, out_code0};
                got.last = last_out;
                if (expected_rows.size() == 0)
                    report_mismatch($sformatf("row %0d not expected, out_code0", rows_checked),
                                    got.code[0], '0);
                else
                begin
                    want = expected_rows.pop_front();
                    for (int c = 0; c < NCH; c++)
                        if (got.code[c] !== want.code[c])
                            report_mismatch($sformatf("row %0d out_code%0d", rows_checked, c),
                                            got.code[c], want.code[c]);
                    if (got.last !== want.last)
                        report_mismatch($sformatf("row %0d last_out", rows_checked),
                                        CODE_BITS'(got.last), CODE_BITS'(want.last));
                end
                rows_checked++;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin : test_flow
        int random_words;
        int budget;
        int active;
        code_t pad;
        random_words = 0;

        // every input known from time zero
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_code0   = '0;
        in_code1   = '0;
        in_code2   = '0;
        in_code3   = '0;
        in_code4   = '0;
        in_code5   = '0;
        in_code6   = '0;
        in_code7   = '0;
        last_frame = 1'b0;
        out_ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_ACTIVE;
        cfg_data   = '0;

        // predictor at reset defaults
        active_reg = 4'd8;
        pad_reg    = 12'd1024;
        dir_reg    = DIR_DELAY;
        rows_seen  = 0;
        foreach (code_hist[c, d])
            code_hist[c][d] = pad_reg;

        repeat (RESET_TICKS) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults, delay mode: field extremes, then a one-frame sequence
        push_word(FILL_ZERO, 1'b0);
        push_word(FILL_ONES, 1'b0);
        push_word(FILL_CHECKER, 1'b0);
        push_word(FILL_RANDOM, 1'b1);
        push_word(FILL_ONES, 1'b1);
        wait_idle();

        // single channel: the frame row itself carries last_out
        apply_settings(1, '0, DIR_DELAY);
        push_word(FILL_ONES, 1'b0);
        push_word(FILL_CHECKER, 1'b1);
        wait_idle();

        // undelay at full width, then a sequence too short for any row
        apply_settings(NCH, '1, DIR_UNDELAY);
        for (int i = 0; i < 9; i++)
            push_word(FILL_RANDOM, i == 8);
        push_word(FILL_ONES, 1'b0);
        push_word(FILL_ZERO, 1'b1);
        wait_idle();

        // channel count zero acts as one
        apply_settings(0, 12'h3C5, DIR_UNDELAY);
        push_word(FILL_RANDOM, 1'b0);
        push_word(FILL_RANDOM, 1'b1);
        wait_idle();

        // channel count above range acts as full width
        apply_settings(15, any_code(), DIR_DELAY);
        push_word(FILL_RANDOM, 1'b0);
        push_word(FILL_RANDOM, 1'b1);
        wait_idle();

        // settings change inside a sequence keeps the delay lines
        apply_settings(3, 12'h0F0, DIR_DELAY);
        push_word(FILL_RANDOM, 1'b0);
        push_word(FILL_RANDOM, 1'b0);
        wait_idle();
        apply_settings(5, 12'hF0F, DIR_DELAY);
        push_word(FILL_RANDOM, 1'b0);
        push_word(FILL_RANDOM, 1'b1);
        wait_idle();

        // random phases, each with fresh settings
        while (random_words < RANDOM_GOAL)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // out-of-range channel counts: 0 or 9..15
                active = $urandom_range(0, 7);
                active = (active == 0) ? 0 : NCH + active;
            end
            else
                active = $urandom_range(1, NCH);
            case ($urandom_range(0, 5))
                0:       pad = '0;
                1:       pad = '1;
                default: pad = code_t'($urandom);
            endcase
            apply_settings(active, pad, dir_t'($urandom_range(0, 1)));
            budget = $urandom_range(20, 45);
            if (budget > RANDOM_GOAL - random_words)
                budget = RANDOM_GOAL - random_words;
            fill_phase(budget);
            random_words += budget;
            wait_idle();
        end

        $display("covered %0d input words and %0d of %0d predicted rows over %0d settings",
                 words_taken, rows_checked, rows_expected, settings_used);
        $display("both layouts, channel counts 0 to 15, pad extremes and cut sequences");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* codebook_delay_interleaver.f */
hdl/cdi_pkg.sv
hdl/cdi_lane.sv
hdl/cdi_merge.sv
hdl/codebook_delay_interleaver.sv
bench/tb_top.sv
